FILE: hdl/fan_controller_register_block_assert.svh
// assertion macros for the fan controller register block checker
// expects aclk and aresetn to be visible where a macro is used
`ifndef FAN_CONTROLLER_REGISTER_BLOCK_ASSERT_SVH
`define FAN_CONTROLLER_REGISTER_BLOCK_ASSERT_SVH

// consequent checked in the same cycle
`define FCRB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fcrb check failed");

// consequent checked in the cycle after the antecedent
`define FCRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fcrb check failed");

`endif

FILE: hdl/fcrb_pkg.sv
// shared types and constants of the fan controller register block
// used by the top level, its checker and the bench, depends on nothing
package fcrb_pkg;

    localparam int NUM_FANS = 4;

    // one bit per existing fan, at most four
    localparam logic [3:0] LANES = 4'(((1 << NUM_FANS) - 1) & 15);

    localparam int TACH_DEPTH = 2 * NUM_FANS;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_STATUS   = 3'd2,
        CMD_IDENTITY = 3'd3,
        CMD_TACH     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_MINOR = 2'd0,
        CFG_MAJOR = 2'd1
    } cfg_idx_t;

    localparam logic [7:0] ADDR_MINOR     = 8'h00;
    localparam logic [7:0] ADDR_MAJOR     = 8'h01;
    localparam logic [7:0] ADDR_SCRATCH   = 8'h02;
    localparam logic [7:0] ADDR_FAN_BASE  = 8'h10;
    localparam logic [7:0] ADDR_ID_BASE   = 8'h61;
    localparam logic [7:0] ADDR_PRESENT   = 8'h70;
    localparam logic [7:0] ADDR_HEALTHY   = 8'h71;
    localparam logic [7:0] ADDR_LED_FIRST = 8'h73;
    localparam logic [7:0] ADDR_LED_LAST  = 8'h76;
    localparam logic [7:0] ADDR_INT       = 8'h77;
    localparam logic [7:0] ADDR_ID_CHG    = 8'h78;
    localparam logic [7:0] ADDR_PRES_CHG  = 8'h80;
    localparam logic [7:0] ADDR_OK_CHG    = 8'h82;

    // last register offset inside a fan window (duty, then tach bytes)
    localparam logic [3:0] FAN_OFF_LAST = 4'd4;

    localparam logic [15:0] TACH_STALLED = 16'hFFFF;
    localparam logic [4:0]  CODE_MASK    = 5'h1F;

    // change latch slots
    localparam int LAT_OK   = 0;
    localparam int LAT_PRES = 1;
    localparam int LAT_ID   = 2;

    // led mask slots, in register order
    localparam int LED_BLUE  = 0;
    localparam int LED_AMBER = 1;
    localparam int LED_GREEN = 2;
    localparam int LED_RED   = 3;

endpackage

FILE: hdl/fan_controller_register_block.sv
// fan controller register block: bus reads/writes and pin events, one word per cycle while s_ready is high
// depends on fcrb_pkg
//
//  channel  direction  handshake         carries
//  s_*      in         s_valid/s_ready   command, address, data, pin samples, tach period
//  m_*      out        m_valid/m_ready   read byte, interrupt summary, led drive masks
//  cfg_*    in         cfg_wr_en         version bytes, read back over s_*
//
// for every word, state updates and the result register load at the accept edge.
// the result of a word shows on m_* the cycle after it is accepted.
// s_ready is low only while a result waits and m_ready is low.
// aresetn is synchronous, active low; it empties the result stage and resets all state registers, not the result data.
module fan_controller_register_block (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_address,
    input  logic [7:0] s_write_data,
    input  logic [3:0] s_present_pins,
    input  logic [3:0] s_healthy_pins,
    input  logic [1:0] s_fan_select,
    input  logic       s_rotor,
    input  logic [4:0] s_fan_code,
    input  logic [15:0] s_tach_period,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_interrupt,
    output logic [3:0] m_green_drive,
    output logic [3:0] m_red_drive,
    output logic [3:0] m_amber_drive,
    output logic [3:0] m_blue_drive,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wr_data
);
    import fcrb_pkg::*;

    logic [7:0]  minor_reg, major_reg;
    logic [7:0]  scratch_reg, scratch_next;
    logic [7:0]  duty_reg [NUM_FANS];
    logic [7:0]  duty_next [NUM_FANS];
    logic [15:0] tach_reg [TACH_DEPTH];
    logic [15:0] tach_next [TACH_DEPTH];
    logic [4:0]  id_reg [NUM_FANS];
    logic [4:0]  id_next [NUM_FANS];
    logic [3:0]  present_reg, present_next;
    logic [3:0]  healthy_reg, healthy_next;
    logic [3:0]  led_reg [4];
    logic [3:0]  led_next [4];
    logic [3:0]  latch_reg [3];
    logic [3:0]  latch_next [3];

    logic        m_valid_reg;
    logic [7:0]  rd_data_reg, rd_data_next;
    logic        irq_reg;
    logic [3:0]  green_reg, red_reg, amber_reg, blue_reg;

    logic        accept;
    logic [3:0]  fan_off;
    logic [3:0]  reg_off;
    logic [3:0]  reg_off_m1;
    logic [2:0]  tach_idx;
    logic [15:0] tach_word;
    logic [7:0]  led_off;
    logic [7:0]  id_off;
    logic [3:0]  id_lane;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // address decode of the per-fan windows, the led and id registers
    assign fan_off    = s_address[7:4] - 4'd1;
    assign reg_off    = s_address[3:0];
    assign reg_off_m1 = reg_off - 4'd1;
    assign tach_idx   = {fan_off[1:0], reg_off_m1[1]};
    assign tach_word  = tach_reg[tach_idx];
    assign led_off    = s_address - ADDR_LED_FIRST;
    assign id_off     = s_address - ADDR_ID_BASE;
    assign id_lane    = (4'd1 << s_fan_select) & LANES;

    // read mux, same priority as the register map
    always_comb begin
        rd_data_next = '0;
        if (s_command == CMD_READ) begin
            if (s_address == ADDR_MINOR) begin
                rd_data_next = minor_reg;
            end else if (s_address == ADDR_MAJOR) begin
                rd_data_next = major_reg;
            end else if (s_address == ADDR_SCRATCH) begin
                rd_data_next = scratch_reg;
            end else if (s_address == ADDR_OK_CHG) begin
                rd_data_next = {4'd0, latch_reg[LAT_OK]};
            end else if (s_address == ADDR_PRES_CHG) begin
                rd_data_next = {4'd0, latch_reg[LAT_PRES]};
            end else if (s_address == ADDR_ID_CHG) begin
                rd_data_next = {4'd0, latch_reg[LAT_ID]};
            end else if (s_address == ADDR_INT) begin
                rd_data_next = {5'd0, |latch_reg[LAT_ID], |latch_reg[LAT_PRES],
                                |latch_reg[LAT_OK]};
            end else if (s_address == ADDR_PRESENT) begin
                rd_data_next = {4'd0, present_reg};
            end else if (s_address == ADDR_HEALTHY) begin
                rd_data_next = {4'd0, healthy_reg};
            end else if (s_address >= ADDR_LED_FIRST && s_address <= ADDR_LED_LAST) begin
                rd_data_next = {4'd0, led_reg[led_off[1:0]]};
            end else if (s_address >= ADDR_ID_BASE
                         && s_address < ADDR_ID_BASE + 8'(NUM_FANS)) begin
                rd_data_next = {3'd0, id_reg[id_off[1:0]]};
            end else if (s_address >= ADDR_FAN_BASE && fan_off < 4'(NUM_FANS)
                         && reg_off <= FAN_OFF_LAST) begin
                if (reg_off == 4'd0) begin
                    rd_data_next = duty_reg[fan_off[1:0]];
                end else if (reg_off[0]) begin
                    rd_data_next = tach_word[7:0];
                end else begin
                    rd_data_next = tach_word[15:8];
                end
            end
        end
    end

    // state update for the word at the input
    always_comb begin
        scratch_next = scratch_reg;
        duty_next    = duty_reg;
        tach_next    = tach_reg;
        id_next      = id_reg;
        present_next = present_reg;
        healthy_next = healthy_reg;
        led_next     = led_reg;
        latch_next   = latch_reg;
        case (s_command)
            CMD_READ: begin
            end
            CMD_WRITE: begin
                if (s_address == ADDR_SCRATCH) begin
                    scratch_next = s_write_data;
                end else if (s_address == ADDR_OK_CHG) begin
                    latch_next[LAT_OK] = latch_reg[LAT_OK] & ~s_write_data[3:0] & LANES;
                end else if (s_address == ADDR_PRES_CHG) begin
                    latch_next[LAT_PRES] = latch_reg[LAT_PRES] & ~s_write_data[3:0] & LANES;
                end else if (s_address == ADDR_ID_CHG) begin
                    latch_next[LAT_ID] = latch_reg[LAT_ID] & ~s_write_data[3:0] & LANES;
                end else if (s_address >= ADDR_LED_FIRST && s_address <= ADDR_LED_LAST) begin
                    led_next[led_off[1:0]] = s_write_data[3:0] & LANES;
                end else if (s_address >= ADDR_FAN_BASE && reg_off == 4'd0
                             && fan_off < 4'(NUM_FANS)) begin
                    duty_next[fan_off[1:0]] = s_write_data;
                end
            end
            CMD_STATUS: begin
                latch_next[LAT_PRES] = latch_reg[LAT_PRES]
                                       | ((present_reg ^ s_present_pins) & LANES);
                latch_next[LAT_OK]   = latch_reg[LAT_OK]
                                       | ((healthy_reg ^ s_healthy_pins) & LANES);
                present_next = s_present_pins & LANES;
                healthy_next = s_healthy_pins & LANES;
            end
            CMD_IDENTITY: begin
                if (3'(s_fan_select) < 3'(NUM_FANS)) begin
                    if (id_reg[s_fan_select] != (s_fan_code & CODE_MASK)) begin
                        latch_next[LAT_ID] = latch_reg[LAT_ID] | id_lane;
                    end
                    id_next[s_fan_select] = s_fan_code & CODE_MASK;
                end
            end
            CMD_TACH: begin
                if (3'(s_fan_select) < 3'(NUM_FANS)) begin
                    tach_next[{s_fan_select, s_rotor}] = s_tach_period;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minor_reg <= '0;
            major_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MINOR: minor_reg <= cfg_wr_data;
                CFG_MAJOR: major_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scratch_reg <= '0;
            present_reg <= '0;
            healthy_reg <= '0;
            for (int i = 0; i < NUM_FANS; i++) begin
                duty_reg[i] <= '0;
                id_reg[i]   <= '0;
            end
            for (int i = 0; i < TACH_DEPTH; i++) begin
                tach_reg[i] <= TACH_STALLED;
            end
            for (int i = 0; i < 4; i++) begin
                led_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                latch_reg[i] <= '0;
            end
        end else if (accept) begin
            scratch_reg <= scratch_next;
            present_reg <= present_next;
            healthy_reg <= healthy_next;
            duty_reg    <= duty_next;
            id_reg      <= id_next;
            tach_reg    <= tach_next;
            led_reg     <= led_next;
            latch_reg   <= latch_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= rd_data_next;
            irq_reg     <= |(latch_next[LAT_OK] | latch_next[LAT_PRES] | latch_next[LAT_ID]);
            green_reg   <= led_next[LED_GREEN];
            red_reg     <= led_next[LED_RED];
            amber_reg   <= led_next[LED_AMBER];
            blue_reg    <= led_next[LED_BLUE];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = rd_data_reg;
    assign m_interrupt   = irq_reg;
    assign m_green_drive = green_reg;
    assign m_red_drive   = red_reg;
    assign m_amber_drive = amber_reg;
    assign m_blue_drive  = blue_reg;

endmodule

FILE: hdl/fcrb_checker.sv
// port-level checks of the fan controller register block, bound to the top level
// depends on fcrb_pkg and fan_controller_register_block_assert.svh
`include "fan_controller_register_block_assert.svh"

module fcrb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_command,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic [3:0]  m_green_drive
);
    import fcrb_pkg::*;

    // a waiting word keeps its read byte and green mask
    `FCRB_ASSERT_NEXT(a_hold_word, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_green_drive))

    // every accepted word shows up on the next cycle
    `FCRB_ASSERT_NEXT(a_result_next, s_valid && s_ready, m_valid)

    // anything but a bus read gives a zero read byte
    `FCRB_ASSERT_NEXT(a_zero_rd, s_valid && s_ready && s_command != CMD_READ,
                      m_read_data == 8'd0)

    // input only stalls behind a waiting result
    `FCRB_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready)

endmodule

bind fan_controller_register_block fcrb_checker u_fcrb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_command     (s_command),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_data   (m_read_data),
    .m_green_drive (m_green_drive)
);

FILE: bench/fan_controller_register_block_test.sv
// self-checking bench for the fan controller register block: directed table, then random words
// tracks registers, latches and leds in its own copy and checks every reply field
// depends on fcrb_pkg and fan_controller_register_block
module fan_controller_register_block_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcrb_pkg::*;

    localparam logic [2:0] CMD_LAST_CODE = 3'd7;
    localparam logic [7:0] ADDR_UNMAPPED = 8'hFF;
    localparam logic [7:0] FAN0_TACH_LO = 8'(ADDR_FAN_BASE + 1);
    localparam logic [7:0] FAN3_DUTY = 8'(ADDR_FAN_BASE * 4);
    localparam logic [7:0] FAN3_INNER_HI = 8'(ADDR_FAN_BASE * 4 + 4);
    localparam logic [7:0] PAST_LAST_FAN = 8'(ADDR_FAN_BASE * 5 + 4);

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 3;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;
    localparam int PHASE_WORDS = 400;
    localparam logic PIN = 1'b1;
    localparam logic FREE = 1'b0;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  address;
        logic [7:0]  wdata;
        logic [3:0]  present;
        logic [3:0]  healthy;
        logic [1:0]  fan;
        logic        rotor;
        logic [4:0]  code;
        logic [15:0] tach;
    } word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt;
        logic [3:0] green;
        logic [3:0] red;
        logic [3:0] amber;
        logic [3:0] blue;
    } reply_t;

    typedef struct packed {
        word_t      w;
        logic       pinned;
        logic [7:0] pin_byte;
    } row_t;

    typedef struct {
        reply_t     r;
        logic       pinned;
        logic [7:0] pin_byte;
    } due_t;

    localparam int OPENING_COUNT = 27;
    localparam row_t OPENING_WORDS [OPENING_COUNT] = '{
        '{'{CMD_READ, ADDR_MINOR, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_READ, ADDR_MAJOR, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_READ, FAN0_TACH_LO, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'hFF},
        '{'{CMD_READ, FAN3_INNER_HI, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'hFF},
        '{'{CMD_READ, ADDR_INT, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_WRITE, ADDR_SCRATCH, 8'hFF, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_SCRATCH, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'hFF},
        '{'{CMD_WRITE, FAN3_DUTY, 8'hA5, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, FAN3_DUTY, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'hA5},
        '{'{CMD_WRITE, ADDR_LED_FIRST, 8'hFF, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_WRITE, ADDR_LED_LAST, 8'h0F, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_LED_FIRST, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h0F},
        '{'{CMD_STATUS, '0, '0, 4'hF, 4'h0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_PRES_CHG, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h0F},
        '{'{CMD_READ, ADDR_INT, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h02},
        '{'{CMD_WRITE, ADDR_PRES_CHG, 8'hFF, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_INT, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_IDENTITY, '0, '0, '0, '0, 2'd2, '0, 5'h1F, '0}, FREE, '0},
        '{'{CMD_IDENTITY, '0, '0, '0, '0, 2'd2, '0, 5'h1F, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_ID_CHG, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h04},
        '{'{CMD_TACH, '0, '0, '0, '0, 2'd3, 1'b1, '0, 16'h0000}, FREE, '0},
        '{'{CMD_READ, FAN3_INNER_HI, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_WRITE, ADDR_PRESENT, 8'hFF, '0, '0, '0, '0, '0, '0}, FREE, '0},
        '{'{CMD_READ, ADDR_PRESENT, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h0F},
        '{'{CMD_READ, PAST_LAST_FAN, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_LAST_CODE, ADDR_SCRATCH, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00},
        '{'{CMD_READ, ADDR_UNMAPPED, '0, '0, '0, '0, '0, '0, '0}, PIN, 8'h00}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_address;
    logic [7:0]  s_write_data;
    logic [3:0]  s_present_pins;
    logic [3:0]  s_healthy_pins;
    logic [1:0]  s_fan_select;
    logic        s_rotor;
    logic [4:0]  s_fan_code;
    logic [15:0] s_tach_period;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_interrupt;
    logic [3:0]  m_green_drive;
    logic [3:0]  m_red_drive;
    logic [3:0]  m_amber_drive;
    logic [3:0]  m_blue_drive;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wr_data;

    // travels with the word so the tracker knows about a typed-in read byte
    logic        pin_on;
    logic [7:0]  pin_byte;

    // tracked register state
    logic [7:0]  ver_minor;
    logic [7:0]  ver_major;
    logic [7:0]  scratch_byte;
    logic [7:0]  duty_byte [NUM_FANS];
    logic [15:0] tach_ticks [TACH_DEPTH];
    logic [4:0]  ident_code [NUM_FANS];
    logic [3:0]  present_mask;
    logic [3:0]  healthy_mask;
    logic [3:0]  led_mask [4];
    logic [3:0]  change_mask [3];

    due_t replies_due [$];
    int   errors;
    int   quiet_cycles;
    bit   idling;
    bit   hold_req;

    fan_controller_register_block dut (.*);

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic regs_clear();
        ver_minor = '0;
        ver_major = '0;
        scratch_byte = '0;
        present_mask = '0;
        healthy_mask = '0;
        for (int i = 0; i < NUM_FANS; i++) begin
            duty_byte[i] = '0;
            ident_code[i] = '0;
        end
        for (int i = 0; i < TACH_DEPTH; i++) tach_ticks[i] = TACH_STALLED;
        for (int i = 0; i < 4; i++) led_mask[i] = '0;
        for (int i = 0; i < 3; i++) change_mask[i] = '0;
    endtask

    function automatic int latch_slot(logic [7:0] a);
        if (a == ADDR_OK_CHG) return LAT_OK;
        if (a == ADDR_PRES_CHG) return LAT_PRES;
        if (a == ADDR_ID_CHG) return LAT_ID;
        return -1;
    endfunction

    function automatic logic [7:0] regs_read(logic [7:0] a);
        int slot;
        int fi;
        int off;
        logic [15:0] t;
        slot = latch_slot(a);
        fi = int'(a[7:4]) - 1;
        off = int'(a[3:0]);
        if (a == ADDR_MINOR) return ver_minor;
        if (a == ADDR_MAJOR) return ver_major;
        if (a == ADDR_SCRATCH) return scratch_byte;
        if (slot >= 0) return {4'b0, change_mask[slot]};
        if (a == ADDR_INT)
            return {5'b0, change_mask[LAT_ID] != 0, change_mask[LAT_PRES] != 0,
                    change_mask[LAT_OK] != 0};
        if (a == ADDR_PRESENT) return {4'b0, present_mask};
        if (a == ADDR_HEALTHY) return {4'b0, healthy_mask};
        if (a >= ADDR_LED_FIRST && a <= ADDR_LED_LAST)
            return {4'b0, led_mask[int'(a - ADDR_LED_FIRST)]};
        if (a >= ADDR_ID_BASE && int'(a) < int'(ADDR_ID_BASE) + NUM_FANS)
            return {3'b0, ident_code[int'(a - ADDR_ID_BASE)]};
        if (a >= ADDR_FAN_BASE && fi < NUM_FANS && off <= int'(FAN_OFF_LAST)) begin
            if (off == 0) return duty_byte[fi];
            // odd offsets hold the low byte, even ones the high byte
            t = tach_ticks[fi * 2 + (off - 1) / 2];
            return (off % 2 == 1) ? t[7:0] : t[15:8];
        end
        return '0;
    endfunction

    function automatic reply_t regs_apply(word_t w);
        reply_t r;
        int slot;
        int fi;
        r.read_data = '0;
        slot = latch_slot(w.address);
        fi = int'(w.address[7:4]) - 1;
        case (w.command)
            CMD_READ: r.read_data = regs_read(w.address);
            CMD_WRITE: begin
                if (w.address == ADDR_SCRATCH) begin
                    scratch_byte = w.wdata;
                end else if (slot >= 0) begin
                    change_mask[slot] = change_mask[slot] & ~w.wdata[3:0] & LANES;
                end else if (w.address >= ADDR_LED_FIRST && w.address <= ADDR_LED_LAST) begin
                    led_mask[int'(w.address - ADDR_LED_FIRST)] = w.wdata[3:0] & LANES;
                end else if (w.address >= ADDR_FAN_BASE && w.address[3:0] == 4'd0
                             && fi < NUM_FANS) begin
                    duty_byte[fi] = w.wdata;
                end
            end
            CMD_STATUS: begin
                change_mask[LAT_PRES] |= (present_mask ^ w.present) & LANES;
                change_mask[LAT_OK] |= (healthy_mask ^ w.healthy) & LANES;
                present_mask = w.present & LANES;
                healthy_mask = w.healthy & LANES;
            end
            CMD_IDENTITY: begin
                if (int'(w.fan) < NUM_FANS) begin
                    if (ident_code[w.fan] != (w.code & CODE_MASK))
                        change_mask[LAT_ID] |= (4'b1 << w.fan) & LANES;
                    ident_code[w.fan] = w.code & CODE_MASK;
                end
            end
            CMD_TACH: begin
                if (int'(w.fan) < NUM_FANS) tach_ticks[int'(w.fan) * 2 + int'(w.rotor)] = w.tach;
            end
            default: ;
        endcase
        r.interrupt = (change_mask[LAT_OK] | change_mask[LAT_PRES] | change_mask[LAT_ID]) != 0;
        r.green = led_mask[LED_GREEN];
        r.red = led_mask[LED_RED];
        r.amber = led_mask[LED_AMBER];
        r.blue = led_mask[LED_BLUE];
        return r;
    endfunction

    function automatic logic [7:0] draw_address();
        logic [7:0] a;
        case ($urandom_range(0, 7))
            0: a = 8'($urandom);
            1: a = 8'($urandom_range(ADDR_MINOR, ADDR_SCRATCH));
            // fan windows, one past the last fan and one past the last offset included
            2, 3: a = 8'(ADDR_FAN_BASE * $urandom_range(1, NUM_FANS + 1) + $urandom_range(0, 5));
            4: a = 8'($urandom_range(ADDR_ID_BASE - 1, ADDR_ID_BASE + NUM_FANS));
            5: a = 8'($urandom_range(ADDR_PRESENT, ADDR_ID_CHG));
            default: begin
                case ($urandom_range(0, 3))
                    0: a = ADDR_OK_CHG;
                    1: a = ADDR_PRES_CHG;
                    2: a = ADDR_ID_CHG;
                    default: a = ADDR_INT;
                endcase
            end
        endcase
        return a;
    endfunction

    function automatic word_t draw_word();
        word_t w;
        int pick;
        // unused fields carry noise
        w.address = 8'($urandom);
        w.wdata = 8'($urandom);
        w.present = 4'($urandom);
        w.healthy = 4'($urandom);
        w.fan = 2'($urandom);
        w.rotor = 1'($urandom);
        w.code = 5'($urandom);
        w.tach = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.command = CMD_READ;
            w.address = draw_address();
        end else if (pick < 65) begin
            w.command = CMD_WRITE;
            w.address = draw_address();
        end else if (pick < 77) begin
            w.command = CMD_STATUS;
            if ($urandom_range(0, 2) == 0) begin
                w.present = present_mask;
                w.healthy = healthy_mask;
            end
        end else if (pick < 87) begin
            w.command = CMD_IDENTITY;
            if ($urandom_range(0, 1) == 0) w.code = ident_code[w.fan];
        end else if (pick < 97) begin
            w.command = CMD_TACH;
            case ($urandom_range(0, 7))
                0: w.tach = TACH_STALLED;
                1: w.tach = '0;
                default: ;
            endcase
        end else begin
            w.command = 3'($urandom_range(int'(CMD_TACH) + 1, int'(CMD_LAST_CODE)));
        end
        return w;
    endfunction

    task automatic push_word(word_t w, logic pinned, logic [7:0] pb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= w.command;
        s_address <= w.address;
        s_write_data <= w.wdata;
        s_present_pins <= w.present;
        s_healthy_pins <= w.healthy;
        s_fan_select <= w.fan;
        s_rotor <= w.rotor;
        s_fan_code <= w.code;
        s_tach_period <= w.tach;
        pin_on <= pinned;
        pin_byte <= pb;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender stops and waits for every outstanding reply
    task automatic settle();
        s_valid <= 1'b0;
        // wait for an edge first so the tracker has queued the last accepted word
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_versions(logic [7:0] minor, logic [7:0] major);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MINOR;
        cfg_wr_data <= minor;
        @(posedge aclk);
        cfg_index <= CFG_MAJOR;
        cfg_wr_data <= major;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(int count, int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            push_word(draw_word(), FREE, '0);
        end
    endtask

    // tracker: checks replies, then folds accepted words and version writes into the state
    always @(posedge aclk) begin : tracker
        reply_t got;
        due_t   head;
        due_t   fresh;
        word_t  w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_read_data, m_interrupt, m_green_drive, m_red_drive,
                        m_amber_drive, m_blue_drive};
                if (replies_due.size() == 0) begin
                    report_mismatch("reply with nothing pending", int'(got), 0);
                end else begin
                    head = replies_due.pop_front();
                    if (got.read_data != head.r.read_data)
                        report_mismatch("read_data", int'(got.read_data),
                                        int'(head.r.read_data));
                    if (head.pinned && got.read_data != head.pin_byte)
                        report_mismatch("read_data vs table", int'(got.read_data),
                                        int'(head.pin_byte));
                    if (got.interrupt != head.r.interrupt)
                        report_mismatch("interrupt", int'(got.interrupt),
                                        int'(head.r.interrupt));
                    if (got.green != head.r.green)
                        report_mismatch("green_drive", int'(got.green), int'(head.r.green));
                    if (got.red != head.r.red)
                        report_mismatch("red_drive", int'(got.red), int'(head.r.red));
                    if (got.amber != head.r.amber)
                        report_mismatch("amber_drive", int'(got.amber), int'(head.r.amber));
                    if (got.blue != head.r.blue)
                        report_mismatch("blue_drive", int'(got.blue), int'(head.r.blue));
                end
            end
            if (s_valid && s_ready) begin
                w = '{s_command, s_address, s_write_data, s_present_pins, s_healthy_pins,
                      s_fan_select, s_rotor, s_fan_code, s_tach_period};
                fresh.r = regs_apply(w);
                fresh.pinned = pin_on;
                fresh.pin_byte = pin_byte;
                replies_due.push_back(fresh);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MINOR: ver_minor = cfg_wr_data;
                    CFG_MAJOR: ver_major = cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : receiver
        int n;
        m_ready = 1'b1;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                // long back-pressure so the result stage fills and s_ready drops
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_READ;
        s_address = '0;
        s_write_data = '0;
        s_present_pins = '0;
        s_healthy_pins = '0;
        s_fan_select = '0;
        s_rotor = 1'b0;
        s_fan_code = '0;
        s_tach_period = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MINOR;
        cfg_wr_data = '0;
        pin_on = 1'b0;
        pin_byte = '0;
        errors = 0;
        quiet_cycles = 0;
        idling = 1'b1;
        hold_req = 1'b0;
        regs_clear();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < OPENING_COUNT; i++)
            push_word(OPENING_WORDS[i].w, OPENING_WORDS[i].pinned, OPENING_WORDS[i].pin_byte);
        settle();

        set_versions(8'hFF, 8'h00);
        run_random(PHASE_WORDS, PHASE_WORDS / 2);
        settle();

        // a stretch with no idling on either side
        idling = 1'b0;
        set_versions(8'h00, 8'hFF);
        run_random(PHASE_WORDS, -1);
        settle();
        idling = 1'b1;

        set_versions(8'($urandom), 8'($urandom));
        run_random(PHASE_WORDS, -1);
        settle();

        set_versions(8'hFF, 8'hFF);
        run_random(PHASE_WORDS, PHASE_WORDS / 3);
        settle();

        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
